// File: hdl/ppr_pkg.sv
// ----------------------------------------------------------------------------
// Piston position regulator package
// Field types, register indices, reset values and fixed arithmetic constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ppr_pkg;

  // Field types
  typedef logic signed [15:0] delta_t;
  typedef logic signed [31:0] pos_t;
  typedef logic        [15:0] cmd_t;
  typedef logic        [11:0] batt_t;
  typedef logic        [7:0]  hold_t;
  typedef logic        [14:0] drive_t;
  typedef logic        [19:0] filt_t;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_X100      = 3'd0,
    CFG_DEAD_BAND      = 3'd1,
    CFG_RAMP_STEP      = 3'd2,
    CFG_ENABLE_HOLD    = 3'd3,
    CFG_CMD_STOP       = 3'd4,
    CFG_CMD_UP_LIMIT   = 3'd5,
    CFG_CMD_DOWN_LIMIT = 3'd6,
    CFG_MIN_DRIVE      = 3'd7
  } cfg_idx_t;

  // Register reset values
  localparam logic [15:0] GAIN_RST      = 16'd30;
  localparam logic [15:0] DEAD_BAND_RST = 16'd50;
  localparam logic [15:0] RAMP_STEP_RST = 16'd250;
  localparam hold_t       HOLD_RST      = 8'd5;
  localparam cmd_t        CMD_STOP_RST  = 16'd32768;
  localparam cmd_t        CMD_UP_RST    = 16'd65535;
  localparam cmd_t        CMD_DOWN_RST  = 16'd0;
  localparam drive_t      MIN_DRIVE_RST = 15'd0;

  // Battery filter, Q12.8
  localparam int    BATT_THRESHOLD  = 2703;
  localparam int    FILTER_ALPHA_Q8 = 26;
  localparam int    FILTER_KEEP     = 256 - FILTER_ALPHA_Q8;
  localparam int    FILT_SUM_W      = 29;
  localparam filt_t BATT_LOW_LEVEL  = 20'(BATT_THRESHOLD * 256);

  // floor(p / 100) with saturation of the quotient to +/-65536
  localparam int PROD_W      = 49;
  localparam int DIV_IN_W    = 24;
  localparam int RECIP_SHIFT = 31;
  localparam int RECIP       = 21474837;       // ceil(2^31 / 100)
  localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
  localparam int SAT_HI      = 6553600;        // 100 * 65536
  localparam int SAT_LO      = 6553500;        // 100 * 65535
  localparam int VAL_W       = 19;
  localparam int VAL_SAT     = 65536;

endpackage

`default_nettype wire

// File: hdl/ppr_in_if.sv
// ----------------------------------------------------------------------------
// Piston position regulator input channel
// Valid/ready channel carrying one regulation tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ppr_in_if;
  import ppr_pkg::*;

  logic   valid;
  logic   ready;
  delta_t encoder_delta;
  pos_t   target_position;
  logic   regulate;
  cmd_t   manual_demand;
  logic   zero_position;
  logic   top_switch_hit;
  logic   bottom_switch_hit;
  batt_t  batt_sample;

  modport source (
    output valid, encoder_delta, target_position, regulate, manual_demand,
           zero_position, top_switch_hit, bottom_switch_hit, batt_sample,
    input  ready
  );

  modport sink (
    input  valid, encoder_delta, target_position, regulate, manual_demand,
           zero_position, top_switch_hit, bottom_switch_hit, batt_sample,
    output ready
  );

endinterface

`default_nettype wire

// File: hdl/ppr_out_if.sv
// ----------------------------------------------------------------------------
// Piston position regulator result channel
// Valid/ready channel carrying one result per tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ppr_out_if;
  import ppr_pkg::*;

  logic  valid;
  logic  ready;
  cmd_t  motor_command;
  logic  drive_enable;
  pos_t  position_count;
  pos_t  track_error;
  logic  batt_low;
  batt_t batt_level;

  modport source (
    output valid, motor_command, drive_enable, position_count, track_error,
           batt_low, batt_level,
    input  ready
  );

  modport sink (
    input  valid, motor_command, drive_enable, position_count, track_error,
           batt_low, batt_level,
    output ready
  );

endinterface

`default_nettype wire

// File: hdl/piston_position_regulator.sv
// ----------------------------------------------------------------------------
// Piston position regulator
// Each input transfer passes stages 1 to 5; the result is held in the stage 5 register.
// Throughput: one tick per cycle while the result side is ready; five pipeline
// stages, each advancing on its own so bubbles collapse and input is taken while a result waits.
// Reset (rst_n, synchronous): pipeline empty, registers and state to defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module piston_position_regulator (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  ppr_in_if.sink                                in_ch,
  ppr_out_if.source                             out_ch,
  input  wire logic                             cfg_we,
  input  wire logic [ppr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ppr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import ppr_pkg::*;

  // Configuration
  logic [15:0] gain_r, dead_band_r, ramp_step_r;
  hold_t       enable_hold_r;
  cmd_t        cmd_stop_r, cmd_up_r, cmd_down_r;
  drive_t      min_drive_r;

  // Stage valids and flow control
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic acc, ld2, ld3, ld4, ld5;

  // Stage 1: position, error, battery filter (these are the state)
  pos_t  position_acc_r, position_acc_nxt;
  pos_t  error_r, error_nxt;
  filt_t batt_filter_r, batt_filter_nxt;
  logic  s1_reg_r, s1_top_r, s1_bot_r;
  cmd_t  s1_man_r;

  // Stage 2: product and dead band test
  logic signed [PROD_W-1:0] s2_prod_r, s2_prod_nxt;
  logic                     s2_out_r, s2_out_nxt;
  pos_t                     s2_pos_r, s2_err_r;
  logic                     s2_low_r, s2_reg_r, s2_top_r, s2_bot_r;
  batt_t                    s2_lvl_r;
  cmd_t                     s2_man_r;
  logic [32:0]              err_ext, err_mag;

  // Stage 3: reciprocal product
  logic [PROD_W-1:0]   s3_qm_r, s3_qm_nxt;
  logic                s3_hi_r, s3_hi_nxt, s3_lo_r, s3_lo_nxt;
  logic [DIV_IN_W-1:0] div_in;
  logic                s3_out_r, s3_low_r, s3_reg_r, s3_top_r, s3_bot_r;
  pos_t                s3_pos_r, s3_err_r;
  batt_t               s3_lvl_r;
  cmd_t                s3_man_r;

  // Stage 4: demand
  cmd_t                    demand_r, demand_nxt;
  logic signed [VAL_W-1:0] val, v_up, v_dn, sp_up, sp_dn;
  logic signed [VAL_W-1:0] md_s, stop_s, up_s, down_s;
  logic                    s4_low_r, s4_top_r, s4_bot_r;
  pos_t                    s4_pos_r, s4_err_r;
  batt_t                   s4_lvl_r;

  // Stage 5: ramp, switch block, enable (result register)
  cmd_t  command_r, command_nxt;
  hold_t hold_r, hold_nxt;
  logic  enable_r, enable_nxt;
  logic  blk;
  cmd_t  gap;
  pos_t  s5_pos_r, s5_err_r;
  logic  s5_low_r;
  batt_t s5_lvl_r;

  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r        <= GAIN_RST;
      dead_band_r   <= DEAD_BAND_RST;
      ramp_step_r   <= RAMP_STEP_RST;
      enable_hold_r <= HOLD_RST;
      cmd_stop_r    <= CMD_STOP_RST;
      cmd_up_r      <= CMD_UP_RST;
      cmd_down_r    <= CMD_DOWN_RST;
      min_drive_r   <= MIN_DRIVE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_GAIN_X100:      gain_r        <= cfg_wdata;
        CFG_DEAD_BAND:      dead_band_r   <= cfg_wdata;
        CFG_RAMP_STEP:      ramp_step_r   <= cfg_wdata;
        CFG_ENABLE_HOLD:    enable_hold_r <= cfg_wdata[7:0];
        CFG_CMD_STOP:       cmd_stop_r    <= cfg_wdata;
        CFG_CMD_UP_LIMIT:   cmd_up_r      <= cfg_wdata;
        CFG_CMD_DOWN_LIMIT: cmd_down_r    <= cfg_wdata;
        CFG_MIN_DRIVE:      min_drive_r   <= cfg_wdata[14:0];
      endcase
    end
  end

  // --------------------------------------------------------------------------
  assign rdy5 = !s5_v_r || out_ch.ready;
  assign rdy4 = !s4_v_r || rdy5;
  assign rdy3 = !s3_v_r || rdy4;
  assign rdy2 = !s2_v_r || rdy3;
  assign rdy1 = !s1_v_r || rdy2;

  assign in_ch.ready = rdy1;
  assign acc = in_ch.valid && rdy1;
  assign ld2 = s1_v_r && rdy2;
  assign ld3 = s2_v_r && rdy3;
  assign ld4 = s3_v_r && rdy4;
  assign ld5 = s4_v_r && rdy5;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else begin
      if (rdy1) s1_v_r <= in_ch.valid;
      if (rdy2) s2_v_r <= s1_v_r;
      if (rdy3) s3_v_r <= s2_v_r;
      if (rdy4) s4_v_r <= s3_v_r;
      if (rdy5) s5_v_r <= s4_v_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1
  always_comb begin
    position_acc_nxt = (in_ch.zero_position ? 32'sd0 : position_acc_r)
                       + 32'(in_ch.encoder_delta);
    error_nxt        = in_ch.regulate
                       ? in_ch.target_position
                         - (in_ch.zero_position ? 32'sd0 : position_acc_r)
                         - 32'(in_ch.encoder_delta)
                       : error_r;
    batt_filter_nxt  = filt_t'((FILT_SUM_W'(batt_filter_r) * FILT_SUM_W'(FILTER_KEEP)
                       + FILT_SUM_W'(in_ch.batt_sample) * FILT_SUM_W'(FILTER_ALPHA_Q8 * 256))
                       >> 8);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_acc_r <= '0;
      error_r        <= '0;
      batt_filter_r  <= BATT_LOW_LEVEL;
    end else if (acc) begin
      position_acc_r <= position_acc_nxt;
      error_r        <= error_nxt;
      batt_filter_r  <= batt_filter_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_reg_r <= in_ch.regulate;
      s1_man_r <= in_ch.manual_demand;
      s1_top_r <= in_ch.top_switch_hit;
      s1_bot_r <= in_ch.bottom_switch_hit;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2
  always_comb begin
    s2_prod_nxt = $signed(error_r) * $signed({1'b0, gain_r});
    err_ext     = {error_r[31], error_r};
    err_mag     = err_ext[32] ? (33'd0 - err_ext) : err_ext;
    s2_out_nxt  = err_mag > {17'd0, dead_band_r};
  end

  always_ff @(posedge clk) begin
    if (ld2) begin
      s2_prod_r <= s2_prod_nxt;
      s2_out_r  <= s2_out_nxt;
      s2_pos_r  <= position_acc_r;
      s2_err_r  <= error_r;
      s2_low_r  <= batt_filter_r < BATT_LOW_LEVEL;
      s2_lvl_r  <= batt_filter_r[19:8];
      s2_reg_r  <= s1_reg_r;
      s2_man_r  <= s1_man_r;
      s2_top_r  <= s1_top_r;
      s2_bot_r  <= s1_bot_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: floor division by 100 through the offset, always non-negative
  always_comb begin
    s3_hi_nxt = s2_prod_r >= PROD_W'(SAT_HI);
    s3_lo_nxt = s2_prod_r < -PROD_W'(SAT_LO);
    div_in    = s2_prod_r[DIV_IN_W-1:0] + DIV_IN_W'(SAT_HI);
    s3_qm_nxt = PROD_W'(div_in) * PROD_W'(RECIP);
  end

  always_ff @(posedge clk) begin
    if (ld3) begin
      s3_qm_r  <= s3_qm_nxt;
      s3_hi_r  <= s3_hi_nxt;
      s3_lo_r  <= s3_lo_nxt;
      s3_out_r <= s2_out_r;
      s3_pos_r <= s2_pos_r;
      s3_err_r <= s2_err_r;
      s3_low_r <= s2_low_r;
      s3_lvl_r <= s2_lvl_r;
      s3_reg_r <= s2_reg_r;
      s3_man_r <= s2_man_r;
      s3_top_r <= s2_top_r;
      s3_bot_r <= s2_bot_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4
  always_comb begin
    md_s   = VAL_W'($signed({1'b0, min_drive_r}));
    stop_s = VAL_W'($signed({1'b0, cmd_stop_r}));
    up_s   = VAL_W'($signed({1'b0, cmd_up_r}));
    down_s = VAL_W'($signed({1'b0, cmd_down_r}));

    if (s3_hi_r)      val = VAL_W'(VAL_SAT);
    else if (s3_lo_r) val = -VAL_W'(VAL_SAT);
    else              val = $signed({1'b0, s3_qm_r[PROD_W-1:RECIP_SHIFT]}) - VAL_W'(VAL_SAT);

    v_up  = ((val > md_s) ? val : md_s) + stop_s;
    sp_up = (v_up < up_s) ? v_up : up_s;
    v_dn  = ((val < -md_s) ? val : -md_s) + stop_s;
    sp_dn = (v_dn > down_s) ? v_dn : down_s;

    if (!s3_reg_r)      demand_nxt = s3_man_r;
    else if (!s3_out_r) demand_nxt = cmd_stop_r;
    else if (!val[VAL_W-1]) demand_nxt = sp_up[15:0];
    else                demand_nxt = sp_dn[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      demand_r <= CMD_STOP_RST;
    end else if (ld4) begin
      demand_r <= demand_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld4) begin
      s4_pos_r <= s3_pos_r;
      s4_err_r <= s3_err_r;
      s4_low_r <= s3_low_r;
      s4_lvl_r <= s3_lvl_r;
      s4_top_r <= s3_top_r;
      s4_bot_r <= s3_bot_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5
  always_comb begin
    blk = ((demand_r < cmd_stop_r) && s4_bot_r)
       || ((demand_r > cmd_stop_r) && s4_top_r);
    gap = (demand_r >= command_r) ? (demand_r - command_r)
                                  : (command_r - demand_r);
    if (blk)                   command_nxt = cmd_stop_r;
    else if (gap > ramp_step_r) command_nxt = (command_r < demand_r)
                                             ? (command_r + ramp_step_r)
                                             : (command_r - ramp_step_r);
    else                       command_nxt = demand_r;

    hold_nxt   = hold_r;
    enable_nxt = enable_r;
    if (command_nxt == cmd_stop_r) begin
      if (hold_r != '0) hold_nxt   = hold_r - 8'd1;
      else              enable_nxt = 1'b0;
    end else begin
      enable_nxt = 1'b1;
      hold_nxt   = enable_hold_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      command_r <= CMD_STOP_RST;
      hold_r    <= HOLD_RST;
      enable_r  <= 1'b0;
    end else if (ld5) begin
      command_r <= command_nxt;
      hold_r    <= hold_nxt;
      enable_r  <= enable_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld5) begin
      s5_pos_r <= s4_pos_r;
      s5_err_r <= s4_err_r;
      s5_low_r <= s4_low_r;
      s5_lvl_r <= s4_lvl_r;
    end
  end

  assign out_ch.valid          = s5_v_r;
  assign out_ch.motor_command  = command_r;
  assign out_ch.drive_enable   = enable_r;
  assign out_ch.position_count = s5_pos_r;
  assign out_ch.track_error    = s5_err_r;
  assign out_ch.batt_low       = s5_low_r;
  assign out_ch.batt_level     = s5_lvl_r;

  // --------------------------------------------------------------------------
  a_full_when_stalled : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_v_r && s2_v_r && s3_v_r && s4_v_r && s5_v_r))
    else $error("input stalled with a bubble in the pipeline");

  a_enable_drop_at_stop : assert property (@(posedge clk) disable iff (!rst_n)
    $fell(enable_r) |-> (command_r == cmd_stop_r))
    else $error("enable dropped away from stop");

  a_ramp_bound : assert property (@(posedge clk) disable iff (!rst_n)
    (ld5 && !blk) |=> (((command_r >= $past(command_r))
                        ? (command_r - $past(command_r))
                        : ($past(command_r) - command_r)) <= $past(ramp_step_r)))
    else $error("command moved by more than the ramp step");

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Piston position regulator testbench
// Sends regulation ticks over the input channel and predicts each result
// with its own model of the regulator. Every result transfer is checked field
// by field. Directed ticks come first, then random ticks under eight register
// settings. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import ppr_pkg::*;

  localparam int TICKS_PER_SETTING = 119;
  localparam int HALF_PERIOD       = 4;

  typedef struct {
    delta_t encoder_delta;
    pos_t   target_position;
    logic   regulate;
    cmd_t   manual_demand;
    logic   zero_position;
    logic   top_switch_hit;
    logic   bottom_switch_hit;
    batt_t  batt_sample;
  } tick_t;

  typedef struct {
    cmd_t  motor_command;
    logic  drive_enable;
    pos_t  position_count;
    pos_t  track_error;
    logic  batt_low;
    batt_t batt_level;
  } reading_t;

  typedef struct {
    logic [15:0] gain;
    logic [15:0] dead;
    logic [15:0] ramp;
    hold_t       hold;
    cmd_t        stop;
    cmd_t        up_lim;
    cmd_t        down_lim;
    drive_t      min_drv;
  } settings_t;

  typedef enum int {
    SET_DEFAULT,
    SET_TYPICAL,
    SET_ALL_ZERO,
    SET_ALL_MAX,
    SET_CROSSED,
    SET_FAST_RAMP,
    SET_ANY,
    SET_STEEP
  } settings_kind_t;

  class regulator_scoreboard;
    localparam int MAX_REPORTS = 40;

    logic [15:0] gain, dead, ramp;
    hold_t       hold_reload;
    cmd_t        stop, up_lim, down_lim;
    drive_t      min_drv;

    pos_t  position;
    pos_t  error;
    cmd_t  demand;
    cmd_t  command;
    hold_t hold_left;
    logic  enable;
    filt_t batt_filt;

    reading_t expected_readings[$];
    int mismatches, checked, n_dead, n_blocked, n_drops;

    function new();
      gain        = GAIN_RST;
      dead        = DEAD_BAND_RST;
      ramp        = RAMP_STEP_RST;
      hold_reload = HOLD_RST;
      stop        = CMD_STOP_RST;
      up_lim      = CMD_UP_RST;
      down_lim    = CMD_DOWN_RST;
      min_drv     = MIN_DRIVE_RST;
      position    = '0;
      error       = '0;
      demand      = CMD_STOP_RST;
      command     = CMD_STOP_RST;
      hold_left   = 8'd5;
      enable      = 1'b0;
      batt_filt   = BATT_LOW_LEVEL;
      mismatches  = 0;
      checked     = 0;
      n_dead      = 0;
      n_blocked   = 0;
      n_drops     = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [15:0] v);
      case (idx)
        CFG_GAIN_X100:      gain        = v;
        CFG_DEAD_BAND:      dead        = v;
        CFG_RAMP_STEP:      ramp        = v;
        CFG_ENABLE_HOLD:    hold_reload = v[7:0];
        CFG_CMD_STOP:       stop        = v;
        CFG_CMD_UP_LIMIT:   up_lim      = v;
        CFG_CMD_DOWN_LIMIT: down_lim    = v;
        CFG_MIN_DRIVE:      min_drv     = v[14:0];
        default: ;
      endcase
    endfunction

    // one regulation tick; pushes the reading it should produce
    function void note_tick(tick_t t);
      longint   err, mag, prod, val, lim, v, sp, cmd, stp, diff, f;
      reading_t r;
      if (t.zero_position) position = '0;
      position = position + pos_t'(t.encoder_delta);

      f = (longint'(batt_filt) * FILTER_KEEP
           + longint'(t.batt_sample) * 256 * FILTER_ALPHA_Q8) >>> 8;
      batt_filt = f[19:0];

      stp = longint'(stop);
      if (t.regulate) begin
        error = t.target_position - position;
        err = longint'(error);
        mag = (err < 0) ? -err : err;
        if (mag > longint'(dead)) begin
          prod = err * longint'(gain);
          val = prod / 100;
          if ((prod % 100) != 0 && prod < 0) val = val - 1;
          if (val >= 0) begin
            v = ((val > longint'(min_drv)) ? val : longint'(min_drv)) + stp;
            sp = (v < longint'(up_lim)) ? v : longint'(up_lim);
          end else begin
            lim = -longint'(min_drv);
            v = ((val < lim) ? val : lim) + stp;
            sp = (v > longint'(down_lim)) ? v : longint'(down_lim);
          end
        end else begin
          sp = stp;
          n_dead++;
        end
        demand = sp[15:0];
      end else begin
        demand = t.manual_demand;
      end

      sp = longint'(demand);
      cmd = longint'(command);
      if ((sp < stp && t.bottom_switch_hit) || (sp > stp && t.top_switch_hit)) begin
        cmd = stp;
        n_blocked++;
      end else begin
        diff = sp - cmd;
        mag = (diff < 0) ? -diff : diff;
        if (mag > longint'(ramp))
          cmd = (cmd < sp) ? cmd + longint'(ramp) : cmd - longint'(ramp);
        else
          cmd = sp;
      end
      command = cmd[15:0];

      if (command == stop) begin
        if (hold_left > 0) begin
          hold_left--;
        end else begin
          if (enable) n_drops++;
          enable = 1'b0;
        end
      end else begin
        enable = 1'b1;
        hold_left = hold_reload;
      end

      r.motor_command  = command;
      r.drive_enable   = enable;
      r.position_count = position;
      r.track_error    = error;
      r.batt_low       = (batt_filt < BATT_LOW_LEVEL);
      r.batt_level     = batt_filt[19:8];
      expected_readings.push_back(r);
    endfunction

    function void compare_field(string name, logic signed [63:0] want,
                                logic signed [63:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_reading(reading_t got);
      reading_t want;
      if (expected_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: reading with nothing expected, expected none, actual command %0d",
                   $time, got.motor_command);
        return;
      end
      want = expected_readings.pop_front();
      checked++;
      compare_field("motor_command",  want.motor_command,  got.motor_command);
      compare_field("drive_enable",   want.drive_enable,   got.drive_enable);
      compare_field("position_count", want.position_count, got.position_count);
      compare_field("track_error",    want.track_error,    got.track_error);
      compare_field("batt_low",       want.batt_low,       got.batt_low);
      compare_field("batt_level",     want.batt_level,     got.batt_level);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ppr_in_if  in_ch ();
  ppr_out_if out_ch ();

  piston_position_regulator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  regulator_scoreboard sb;
  bit calm_in, calm_out;
  int batt_base = BATT_THRESHOLD;
  int n_settings;

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic settings_t make_settings(settings_kind_t k);
    settings_t s;
    s = '{GAIN_RST, DEAD_BAND_RST, RAMP_STEP_RST, HOLD_RST,
          CMD_STOP_RST, CMD_UP_RST, CMD_DOWN_RST, MIN_DRIVE_RST};
    case (k)
      SET_TYPICAL: begin
        s.gain    = 16'($urandom_range(50, 500));
        s.dead    = 16'($urandom_range(0, 200));
        s.ramp    = 16'($urandom_range(100, 5000));
        s.hold    = 8'($urandom_range(0, 10));
        s.min_drv = 15'($urandom_range(0, 2000));
      end
      SET_ALL_ZERO: s = '{default: 0};
      SET_ALL_MAX:
        s = '{16'hffff, 16'hffff, 16'hffff, 8'hff, 16'hffff, 16'hffff, 16'hffff, 15'h7fff};
      SET_CROSSED: begin
        s.stop     = 16'($urandom_range(16384, 49151));
        s.up_lim   = 16'($urandom_range(0, s.stop - 1));
        s.down_lim = 16'($urandom_range(s.stop + 1, 65535));
        s.gain     = 16'($urandom_range(20, 300));
        s.dead     = 16'($urandom_range(0, 100));
        s.ramp     = 16'($urandom_range(500, 20000));
        s.min_drv  = 15'($urandom_range(0, 4000));
      end
      SET_FAST_RAMP: begin
        s.ramp = 16'hffff;
        s.hold = 8'($urandom_range(0, 3));
        s.gain = 16'($urandom_range(100, 2000));
        s.dead = 16'($urandom_range(0, 20));
        s.stop = 16'($urandom);
      end
      SET_ANY: begin
        s.gain     = 16'($urandom);
        s.dead     = 16'($urandom);
        s.ramp     = 16'($urandom);
        s.hold     = 8'($urandom);
        s.stop     = 16'($urandom);
        s.up_lim   = 16'($urandom);
        s.down_lim = 16'($urandom);
        s.min_drv  = 15'($urandom);
      end
      SET_STEEP: begin
        s.gain    = 16'($urandom_range(20000, 65535));
        s.dead    = 16'($urandom_range(0, 5));
        s.ramp    = 16'($urandom_range(1000, 65535));
        s.min_drv = 15'($urandom_range(0, 32767));
      end
      default: ;
    endcase
    return s;
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    sb.set_reg(idx, v);
    @(negedge clk);
  endtask

  task automatic apply_settings(settings_t s);
    write_reg(CFG_GAIN_X100,      s.gain);
    write_reg(CFG_DEAD_BAND,      s.dead);
    write_reg(CFG_RAMP_STEP,      s.ramp);
    write_reg(CFG_ENABLE_HOLD,    16'(s.hold));
    write_reg(CFG_CMD_STOP,       s.stop);
    write_reg(CFG_CMD_UP_LIMIT,   s.up_lim);
    write_reg(CFG_CMD_DOWN_LIMIT, s.down_lim);
    write_reg(CFG_MIN_DRIVE,      16'(s.min_drv));
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_tick(tick_t t);
    int gap;
    if ($urandom_range(0, 39) == 0) calm_in = !calm_in;
    gap = calm_in ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid             <= 1'b1;
    in_ch.encoder_delta     <= t.encoder_delta;
    in_ch.target_position   <= t.target_position;
    in_ch.regulate          <= t.regulate;
    in_ch.manual_demand     <= t.manual_demand;
    in_ch.zero_position     <= t.zero_position;
    in_ch.top_switch_hit    <= t.top_switch_hit;
    in_ch.bottom_switch_hit <= t.bottom_switch_hit;
    in_ch.batt_sample       <= t.batt_sample;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_tick(t);
    @(negedge clk);
  endtask

  task automatic apply_tick(delta_t d, pos_t tgt, logic on, cmd_t man, logic clr,
                            logic top, logic bot, batt_t smp);
    tick_t t;
    t = '{d, tgt, on, man, clr, top, bot, smp};
    send_tick(t);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.expected_readings.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic tick_t random_tick();
    tick_t t;
    pos_t  next_pos;
    int    off;
    int    kind;
    int    smp;
    t.zero_position = ($urandom_range(0, 19) == 0);
    kind = $urandom_range(0, 9);
    if (kind == 0)
      t.encoder_delta = delta_t'($urandom);
    else if (kind == 1)
      t.encoder_delta = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    else
      t.encoder_delta = delta_t'($urandom_range(0, 400)) - 16'sd200;

    next_pos = (t.zero_position ? pos_t'(0) : sb.position) + pos_t'(t.encoder_delta);
    kind = $urandom_range(0, 9);
    case (kind)
      0: t.target_position = pos_t'($urandom);
      1: t.target_position = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      2, 3, 4: begin
        // close to the dead band edge
        off = int'(sb.dead) + int'($urandom_range(0, 2)) - 1;
        t.target_position = next_pos + ($urandom_range(0, 1) ? off : -off);
      end
      default: begin
        off = $urandom_range(0, 20000);
        t.target_position = next_pos + ($urandom_range(0, 1) ? off : -off);
      end
    endcase

    t.regulate = ($urandom_range(0, 99) < 85);
    t.manual_demand = ($urandom_range(0, 3) == 0) ? sb.stop : cmd_t'($urandom);
    t.top_switch_hit    = ($urandom_range(0, 6) == 0);
    t.bottom_switch_hit = ($urandom_range(0, 6) == 0);

    if ($urandom_range(0, 29) == 0)
      batt_base = $urandom_range(0, 1) ? $urandom_range(0, 4095) : $urandom_range(2600, 2800);
    if ($urandom_range(0, 9) == 0) begin
      t.batt_sample = batt_t'($urandom);
    end else begin
      smp = batt_base + int'($urandom_range(0, 40)) - 20;
      if (smp < 0) smp = 0;
      if (smp > 4095) smp = 4095;
      t.batt_sample = batt_t'(smp);
    end
    return t;
  endfunction

  // result side
  initial begin
    reading_t got;
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) calm_out = !calm_out;
      stall = calm_out ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got.motor_command  = out_ch.motor_command;
      got.drive_enable   = out_ch.drive_enable;
      got.position_count = out_ch.position_count;
      got.track_error    = out_ch.track_error;
      got.batt_low       = out_ch.batt_low;
      got.batt_level     = out_ch.batt_level;
      sb.check_reading(got);
      @(negedge clk);
    end
  end

  // stimulus
  initial begin
    settings_t      s;
    settings_kind_t k;
    sb = new();
    n_settings = 0;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    in_ch.valid             = 1'b0;
    in_ch.encoder_delta     = '0;
    in_ch.target_position   = '0;
    in_ch.regulate          = 1'b0;
    in_ch.manual_demand     = '0;
    in_ch.zero_position     = 1'b0;
    in_ch.top_switch_hit    = 1'b0;
    in_ch.bottom_switch_hit = 1'b0;
    in_ch.batt_sample       = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    apply_settings(make_settings(SET_DEFAULT));
    apply_tick(16'sd0,    32'sd0,        1'b1, 16'd0, 1'b1, 1'b0, 1'b0, 12'd2703);
    apply_tick(16'sh7fff, 32'sd0,        1'b1, 16'd0, 1'b1, 1'b0, 1'b0, 12'd2703);
    apply_tick(16'sh8000, 32'sd0,        1'b1, 16'd0, 1'b1, 1'b0, 1'b0, 12'd0);
    // error of -2^31, directly and through wrap-around
    apply_tick(16'sd0,    32'sh80000000, 1'b1, 16'd0, 1'b1, 1'b0, 1'b0, 12'hfff);
    apply_tick(-16'sd1,   32'sh7fffffff, 1'b1, 16'd0, 1'b1, 1'b0, 1'b0, 12'hfff);
    // dead band edges
    apply_tick(16'sd0,    32'sd50,       1'b1, 16'd0, 1'b1, 1'b0, 1'b0, 12'd2703);
    apply_tick(16'sd0,    32'sd51,       1'b1, 16'd0, 1'b1, 1'b0, 1'b0, 12'd2703);
    apply_tick(16'sd0,    -32'sd51,      1'b1, 16'd0, 1'b1, 1'b0, 1'b0, 12'd2703);
    apply_tick(16'sd0,    -32'sd50,      1'b1, 16'd0, 1'b1, 1'b0, 1'b0, 12'd2703);
    repeat (6)
      apply_tick(16'sd0,  32'sd0,        1'b1, 16'd0, 1'b1, 1'b0, 1'b0, 12'd2703);
    // manual demand against the end switches
    apply_tick(16'sd0,    32'sd0,        1'b0, 16'hffff, 1'b0, 1'b1, 1'b0, 12'd100);
    apply_tick(16'sd0,    32'sd0,        1'b0, 16'h0000, 1'b0, 1'b0, 1'b1, 12'd100);
    apply_tick(16'sd0,    32'sd0,        1'b0, 16'h0000, 1'b0, 1'b1, 1'b0, 12'd100);
    apply_tick(16'sd0,    32'sd0,        1'b0, 16'hffff, 1'b0, 1'b1, 1'b1, 12'd4000);
    apply_tick(16'sd0,    32'sd0,        1'b0, 16'h8000, 1'b0, 1'b1, 1'b1, 12'd4000);
    drain();

    // proportional term of zero, and floor of a small negative term
    s = make_settings(SET_DEFAULT);
    s.gain    = 16'd1;
    s.dead    = 16'd0;
    s.min_drv = 15'd100;
    apply_settings(s);
    apply_tick(16'sd0, 32'sd5,  1'b1, 16'd0, 1'b1, 1'b0, 1'b0, 12'd2703);
    apply_tick(16'sd0, -32'sd5, 1'b1, 16'd0, 1'b1, 1'b0, 1'b0, 12'd2703);
    apply_tick(16'sd0, 32'sd0,  1'b1, 16'd0, 1'b1, 1'b0, 1'b0, 12'd2703);
    drain();

    k = k.first();
    do begin
      apply_settings(make_settings(k));
      repeat (TICKS_PER_SETTING) send_tick(random_tick());
      drain();
      k = k.next();
    end while (k != k.first());

    repeat (16) @(negedge clk);
    $display("Checked %0d results over %0d register settings.", sb.checked, n_settings);
    $display("Dead band ticks %0d, switch forced stops %0d, enable drops %0d.",
             sb.n_dead, sb.n_blocked, sb.n_drops);
    if (sb.mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
